@@ hdl/gspa_pkg.sv @@
// Shared types, constants and helper functions for the growable slot pool allocator.
`default_nettype none

package gspa_pkg;

    // Pool geometry: the taken map is kept as rows of ROW_W bits
    localparam int SLOTS   = 64;
    localparam int ROW_W   = 16;
    localparam int ROWS    = SLOTS / ROW_W;
    localparam int ROW_AW  = $clog2(ROWS);
    localparam int BIT_AW  = $clog2(ROW_W);
    localparam int SLOT_W  = ROW_AW + BIT_AW;
    localparam int CNT_W   = SLOT_W + 1;
    localparam int TOTAL_W = 32;
    localparam int CFG_AW  = 2;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_INITIAL_SLOTS = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_SLOTS     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_GROW_STEP     = 2'd2;

    typedef enum logic [1:0] {
        MODE_TAKE = 2'd0,
        MODE_GIVE = 2'd1,
        MODE_FIND = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_TAKEN = 2'd2,
        ST_NONE      = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EVAL = 1'b1
    } state_t;

    // Result of evaluating one row of the taken map
    typedef struct packed {
        logic              hit;
        logic [BIT_AW-1:0] bit_pos;
        logic [ROW_W-1:0]  wr_data;
        logic              last_row;
    } row_eval_t;

    // Lowest set bit of a row; zero when none is set
    function automatic logic [BIT_AW-1:0] first_one(input logic [ROW_W-1:0] v);
        logic [BIT_AW-1:0] pos;
        pos = '0;
        for (int j = ROW_W - 1; j >= 0; j--) begin
            if (v[j]) begin
                pos = BIT_AW'(j);
            end
        end
        return pos;
    endfunction

    // Limit a slot count to the pool size
    function automatic logic [CNT_W-1:0] clamp_slots(input logic [CNT_W-1:0] v);
        return (v > SLOTS_CNT) ? SLOTS_CNT : v;
    endfunction

endpackage

`default_nettype wire

@@ hdl/gspa_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module gspa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read every cycle into the output register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/gspa_row_eval.sv @@
// Row evaluator: searches one taken-map row for a free, taken or addressed slot.
`default_nettype none

module gspa_row_eval
    import gspa_pkg::*;
(
    input  wire logic [1:0]        mode,
    input  wire logic [ROW_AW-1:0] row,
    input  wire logic [ROW_W-1:0]  row_data,
    input  wire logic [SLOT_W-1:0] slot_index,
    input  wire logic [CNT_W-1:0]  alloc_len,
    output row_eval_t              result
);

    logic [ROW_W-1:0]  in_range;
    logic [ROW_W-1:0]  at_or_after;
    logic [ROW_W-1:0]  free_bits;
    logic [ROW_W-1:0]  found_bits;
    logic [ROW_W-1:0]  give_mask;
    logic [ROW_AW:0]   next_row;
    logic [CNT_W-1:0]  next_start;

    // Mark slot positions below the allocated length and at or after the start index
    always_comb
    begin
        for (int j = 0; j < ROW_W; j++)
        begin
            in_range[j]    = ({1'b0, row, BIT_AW'(j)} < alloc_len);
            at_or_after[j] = ({row, BIT_AW'(j)} >= slot_index);
        end
    end

    assign free_bits  = ~row_data & in_range;
    assign found_bits = row_data & in_range & at_or_after;
    assign give_mask  = ROW_W'(1) << slot_index[BIT_AW-1:0];

    // Row is last to scan when the next row starts at or past the length, or no row follows
    assign next_row   = {1'b0, row} + (ROW_AW + 1)'(1);
    assign next_start = {next_row, {BIT_AW{1'b0}}};

    always_comb
    begin
        result          = '0;
        result.last_row = (next_start >= alloc_len) || (row == ROW_AW'(ROWS - 1));
        unique case (mode)
            MODE_TAKE:
            begin
                result.hit     = |free_bits;
                result.bit_pos = first_one(free_bits);
                result.wr_data = row_data | (ROW_W'(1) << first_one(free_bits));
            end
            MODE_GIVE:
            begin
                result.hit     = |(row_data & give_mask);
                result.bit_pos = slot_index[BIT_AW-1:0];
                result.wr_data = row_data & ~give_mask;
            end
            MODE_FIND:
            begin
                result.hit     = |found_bits;
                result.bit_pos = first_one(found_bits);
                result.wr_data = row_data;
            end
            default:
            begin
                result.hit     = 1'b0;
                result.bit_pos = '0;
                result.wr_data = row_data;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/growable_slot_pool_allocator_core.sv @@
// Top level of the growable slot pool allocator: sequencer, counters and taken-map RAM.
//
// Usage:
//   Command channel: raise start with mode and slot_index while busy is low; the
//   word is taken at that clock edge. Exactly one result word follows, shown on
//   status, granted_slot, taken_count, allocated_count and total_takes for one
//   cycle while done is high. The receiver cannot stall; the result must be
//   captured in that cycle.
//   Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
//   cfg_ready is high whenever no command is in progress and start is low.
//   Writing initial_slots empties the pool at once (row valid bits are cleared,
//   no sweep).
//   Scan: the taken map is a RAM of 4 rows of 16 slots with a registered read,
//   scanned one row per cycle. The start row is read at accept; a give back
//   evaluates that row only, a take or find moves on row by row until a hit or
//   the last row; done is registered as eval ends. Mode 3 and a take on a full
//   pool register done at accept. A new command may start in the done cycle.
//   Reset: state clears, mode register is NOP, allocated length 8, max 64, growth step 8.
`default_nettype none

module growable_slot_pool_allocator_core
    import gspa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         mode,
    input  wire logic [SLOT_W-1:0]  slot_index,
    // result channel
    output logic                    done,
    output logic [1:0]              status,
    output logic [SLOT_W-1:0]       granted_slot,
    output logic [CNT_W-1:0]        taken_count,
    output logic [CNT_W-1:0]        allocated_count,
    output logic [TOTAL_W-1:0]      total_takes,
    // configuration channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_AW-1:0]  cfg_index,
    input  wire logic [CNT_W-1:0]   cfg_data
);

    state_t               state_reg,   state_next;
    logic [1:0]           mode_reg,    mode_next;
    logic [SLOT_W-1:0]    index_reg,   index_next;
    logic [ROW_AW-1:0]    row_reg,     row_next;
    logic [ROWS-1:0]      valid_reg,   valid_next;
    logic [CNT_W-1:0]     taken_reg,   taken_next;
    logic [CNT_W-1:0]     alloc_reg,   alloc_next;
    logic [TOTAL_W-1:0]   total_reg,   total_next;
    logic [CNT_W-1:0]     max_reg,     max_next;
    logic [CNT_W-1:0]     step_reg,    step_next;
    logic                 done_reg,    done_next;
    status_t              status_reg,  status_next;
    logic [SLOT_W-1:0]    slot_reg,    slot_next;

    logic                 accept;
    logic                 cfg_write;
    logic [CNT_W-1:0]     limit;
    logic [CNT_W:0]       grown;
    logic                 take_full;
    logic [ROW_AW-1:0]    rd_addr;
    logic [ROW_W-1:0]     rd_data;
    logic [ROW_W-1:0]     row_data;
    logic                 wr_en;
    row_eval_t            ev;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    assign limit     = clamp_slots(max_reg);
    assign take_full = (taken_reg >= limit);
    assign grown     = {1'b0, alloc_reg} + {1'b0, step_reg};

    // Read the start row on accept, the following row while scanning
    assign rd_addr  = (state_reg == S_IDLE)
                    ? ((mode == MODE_TAKE) ? '0 : slot_index[SLOT_W-1:BIT_AW])
                    : row_reg + ROW_AW'(1);

    // Rows never written since the pool was emptied read as all free
    assign row_data = valid_reg[row_reg] ? rd_data : '0;

    assign wr_en    = (state_reg == S_EVAL) && ev.hit
                    && ((mode_reg == MODE_TAKE) || (mode_reg == MODE_GIVE));

    gspa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_map_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (row_reg),
        .wdata (ev.wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    gspa_row_eval u_row_eval (
        .mode       (mode_reg),
        .row        (row_reg),
        .row_data   (row_data),
        .slot_index (index_reg),
        .alloc_len  (alloc_reg),
        .result     (ev)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (mode != MODE_NOP) && !((mode == MODE_TAKE) && take_full))
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (ev.hit || ev.last_row || (mode_reg == MODE_GIVE))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and result words
    always_comb
    begin
        mode_next   = mode_reg;
        index_next  = index_reg;
        row_next    = row_reg;
        valid_next  = valid_reg;
        taken_next  = taken_reg;
        alloc_next  = alloc_reg;
        total_next  = total_reg;
        max_next    = max_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Apply configuration writes while idle; initial_slots empties the pool
                if (cfg_write)
                begin
                    priority if (cfg_index == CFG_INITIAL_SLOTS)
                    begin
                        alloc_next = clamp_slots(cfg_data);
                        taken_next = '0;
                        valid_next = '0;
                    end
                    else if (cfg_index == CFG_MAX_SLOTS)
                    begin
                        max_next = cfg_data;
                    end
                    else if (cfg_index == CFG_GROW_STEP)
                    begin
                        step_next = cfg_data;
                    end
                end

                if (accept)
                begin
                    mode_next  = mode;
                    index_next = slot_index;
                    row_next   = rd_addr;
                    priority if (mode == MODE_NOP)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        slot_next   = '0;
                    end
                    else if ((mode == MODE_TAKE) && take_full)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                        slot_next   = '0;
                    end
                    else if ((mode == MODE_TAKE) && (taken_reg >= alloc_reg))
                    begin
                        // Grow by the step, capped at the limit, never shrinking
                        if (grown > {1'b0, limit})
                        begin
                            if (limit > alloc_reg)
                            begin
                                alloc_next = limit;
                            end
                        end
                        else if (grown[CNT_W-1:0] > alloc_reg)
                        begin
                            alloc_next = grown[CNT_W-1:0];
                        end
                    end
                end
            end

            S_EVAL:
            begin
                row_next = row_reg + ROW_AW'(1);
                unique case (mode_reg)
                    MODE_TAKE:
                    begin
                        if (ev.hit)
                        begin
                            valid_next[row_reg] = 1'b1;
                            taken_next  = taken_reg + CNT_W'(1);
                            total_next  = total_reg + TOTAL_W'(1);
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            slot_next   = {row_reg, ev.bit_pos};
                        end
                        else if (ev.last_row)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                            slot_next   = '0;
                        end
                    end
                    MODE_GIVE:
                    begin
                        done_next = 1'b1;
                        slot_next = '0;
                        if (ev.hit)
                        begin
                            valid_next[row_reg] = 1'b1;
                            status_next = ST_OK;
                            if (taken_reg != '0)
                            begin
                                taken_next = taken_reg - CNT_W'(1);
                            end
                        end
                        else
                        begin
                            status_next = ST_NOT_TAKEN;
                        end
                    end
                    MODE_FIND:
                    begin
                        if (ev.hit)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            slot_next   = {row_reg, ev.bit_pos};
                        end
                        else if (ev.last_row)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NONE;
                            slot_next   = '0;
                        end
                    end
                    default:
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        slot_next   = '0;
                    end
                endcase
            end

            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= MODE_NOP;
            index_reg  <= '0;
            row_reg    <= '0;
            valid_reg  <= '0;
            taken_reg  <= '0;
            alloc_reg  <= CNT_W'(8);
            total_reg  <= '0;
            max_reg    <= CNT_W'(64);
            step_reg   <= CNT_W'(8);
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            slot_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            index_reg  <= index_next;
            row_reg    <= row_next;
            valid_reg  <= valid_next;
            taken_reg  <= taken_next;
            alloc_reg  <= alloc_next;
            total_reg  <= total_next;
            max_reg    <= max_next;
            step_reg   <= step_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            slot_reg   <= slot_next;
        end
    end

    // Drive the result word
    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_slot    = slot_reg;
    assign taken_count     = taken_reg;
    assign allocated_count = alloc_reg;
    assign total_takes     = total_reg;

endmodule

`default_nettype wire
